// File: rtl/update_receiver_crc_check_core_defines.svh
// ----------------------------------------------------------------------------
// update receiver crc check core - assertion macros
// shared property forms for the receive controller checks
// ----------------------------------------------------------------------------
`ifndef UPDATE_RECEIVER_CRC_CHECK_CORE_DEFINES_SVH
`define UPDATE_RECEIVER_CRC_CHECK_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define URCC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define URCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/urcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urcc_pkg
// types, codes and crc-32 matrix for the update receiver crc check core
// ----------------------------------------------------------------------------
package urcc_pkg;

    localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
    localparam logic [31:0] CRC_SEED = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_DATA  = 2'd1,
        CMD_END   = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        PH_IDLE      = 2'd0,
        PH_STARTING  = 2'd1,
        PH_RECEIVING = 2'd2,
        PH_DONE      = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_IGNORED  = 2'd1,
        ST_FLASH    = 2'd2,
        ST_MISMATCH = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        KIND_START     = 3'd0,
        KIND_DATA_FULL = 3'd1,
        KIND_DATA_PART = 3'd2,
        KIND_END       = 3'd3,
        KIND_NONE      = 3'd4
    } t_kind;

    // classified item between front and back
    typedef struct packed {
        t_kind       kind;
        logic        flash_ok;
        logic [31:0] payload;   // expected crc on start, folded word on full data
        logic [2:0]  inc;       // byte increment on data (4 on full data)
    } t_entry;

    typedef logic [31:0][31:0] t_crc_cols;

    // image of each single-bit vector under 32 msb-first shift steps
    function automatic t_crc_cols crc_cols();
        t_crc_cols   cols;
        logic [31:0] v;
        for (int j = 0; j < 32; j++) begin
            v = 32'h1 << j;
            for (int b = 0; b < 32; b++) begin
                v = v[31] ? ((v << 1) ^ CRC_POLY) : (v << 1);
            end
            cols[j] = v;
        end
        return cols;
    endfunction

    localparam t_crc_cols CRC_COLS = crc_cols();

    // linear crc fold as a flat xor network
    function automatic logic [31:0] crc_mul(input logic [31:0] v);
        logic [31:0] r;
        r = '0;
        for (int j = 0; j < 32; j++) begin
            if (v[j]) begin
                r = r ^ CRC_COLS[j];
            end
        end
        return r;
    endfunction

endpackage

// File: rtl/urcc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urcc_front
// accepts input items, decodes command and pre-folds the data word
// ----------------------------------------------------------------------------
module urcc_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [1:0]            i_command,
    input  logic [31:0]           i_data_word,
    input  logic [2:0]            i_byte_count,
    input  logic [31:0]           i_expected_crc,
    input  logic                  i_flash_ok,
    output logic                  o_valid,
    input  logic                  i_ready,
    output urcc_pkg::t_entry      o_entry
);

    logic             r_valid;
    urcc_pkg::t_entry r_entry;
    urcc_pkg::t_entry n_entry;
    logic             w_take;
    logic             w_push;

    assign o_ready = !r_valid || i_ready;
    assign w_take  = i_valid && o_ready;
    assign w_push  = r_valid && i_ready;
    assign o_valid = r_valid;
    assign o_entry = r_entry;

    always_comb begin
        n_entry          = '0;
        n_entry.flash_ok = i_flash_ok;
        n_entry.kind     = urcc_pkg::KIND_NONE;
        unique case (urcc_pkg::t_cmd'(i_command))
            urcc_pkg::CMD_START: begin
                n_entry.kind    = urcc_pkg::KIND_START;
                n_entry.payload = i_expected_crc;
            end
            urcc_pkg::CMD_DATA: begin
                if (i_byte_count >= 3'd4) begin
                    n_entry.kind    = urcc_pkg::KIND_DATA_FULL;
                    n_entry.payload = urcc_pkg::crc_mul(i_data_word);
                    n_entry.inc     = 3'd4;
                end else begin
                    n_entry.kind = urcc_pkg::KIND_DATA_PART;
                    n_entry.inc  = i_byte_count;
                end
            end
            urcc_pkg::CMD_END: begin
                n_entry.kind = urcc_pkg::KIND_END;
            end
            default: begin
                n_entry.kind = urcc_pkg::KIND_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (w_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_entry <= n_entry;
        end
    end

endmodule

// File: rtl/urcc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urcc_queue
// two-entry queue of classified items between front and back
// ----------------------------------------------------------------------------
module urcc_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  urcc_pkg::t_entry i_entry,
    output logic             o_valid,
    input  logic             i_ready,
    output urcc_pkg::t_entry o_entry
);

    logic [1:0]       r_count;
    logic [1:0]       n_count;
    urcc_pkg::t_entry r_q0;
    urcc_pkg::t_entry r_q1;
    logic             w_push;
    logic             w_pop;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_entry = r_q0;
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_comb begin
        n_count = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 2'd1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            if (w_push && (r_count == 2'd1)) begin
                r_q0 <= i_entry;
            end else begin
                r_q0 <= r_q1;
            end
            if (w_push && (r_count == 2'd2)) begin
                r_q1 <= i_entry;
            end
        end else if (w_push) begin
            if (r_count == 2'd0) begin
                r_q0 <= i_entry;
            end else begin
                r_q1 <= i_entry;
            end
        end
    end

endmodule

// File: rtl/urcc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urcc_back
// transfer state, running crc update and registered result item
// ----------------------------------------------------------------------------
module urcc_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  urcc_pkg::t_entry     i_entry,
    output logic                 o_m_valid,
    input  logic                 i_m_ready,
    output logic [71:0]          o_m_data
);

    urcc_pkg::t_phase  r_phase;
    urcc_pkg::t_phase  n_phase;
    logic [31:0]       r_crc;
    logic [31:0]       n_crc;
    logic [31:0]       r_total;
    logic [31:0]       n_total;
    logic [31:0]       r_expected;
    logic [31:0]       n_expected;
    urcc_pkg::t_status w_status;
    logic              w_reset_req;
    logic              w_pop;
    logic              w_receiving;
    logic              w_match;
    logic              r_m_valid;
    logic [71:0]       r_m_data;

    assign o_ready     = !r_m_valid || i_m_ready;
    assign w_pop       = i_valid && o_ready;
    assign w_receiving = (r_phase == urcc_pkg::PH_RECEIVING);
    assign w_match     = (r_crc == r_expected);
    assign o_m_valid   = r_m_valid;
    assign o_m_data    = r_m_data;

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (w_pop) begin
            unique case (i_entry.kind)
                urcc_pkg::KIND_START: begin
                    n_phase = i_entry.flash_ok ? urcc_pkg::PH_RECEIVING
                                               : urcc_pkg::PH_STARTING;
                end
                urcc_pkg::KIND_END: begin
                    if (w_receiving) begin
                        n_phase = w_match ? urcc_pkg::PH_DONE : urcc_pkg::PH_IDLE;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    // datapath and result fields
    always_comb begin
        n_crc       = r_crc;
        n_total     = r_total;
        n_expected  = r_expected;
        w_status    = urcc_pkg::ST_OK;
        w_reset_req = 1'b0;
        unique case (i_entry.kind)
            urcc_pkg::KIND_START: begin
                n_expected = i_entry.payload;
                n_crc      = urcc_pkg::CRC_SEED;
                n_total    = '0;
                if (!i_entry.flash_ok) begin
                    w_status = urcc_pkg::ST_FLASH;
                end
            end
            urcc_pkg::KIND_DATA_FULL, urcc_pkg::KIND_DATA_PART: begin
                if (!w_receiving) begin
                    w_status = urcc_pkg::ST_IGNORED;
                end else if (!i_entry.flash_ok) begin
                    w_status = urcc_pkg::ST_FLASH;
                end else begin
                    n_total = r_total + {29'd0, i_entry.inc};
                    if (i_entry.kind == urcc_pkg::KIND_DATA_FULL) begin
                        n_crc = urcc_pkg::crc_mul(r_crc) ^ i_entry.payload;
                    end
                end
            end
            urcc_pkg::KIND_END: begin
                if (!w_receiving) begin
                    w_status = urcc_pkg::ST_IGNORED;
                end else if (w_match) begin
                    w_reset_req = 1'b1;
                end else begin
                    w_status = urcc_pkg::ST_MISMATCH;
                end
            end
            default: begin
                w_status = urcc_pkg::ST_IGNORED;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= urcc_pkg::PH_IDLE;
            r_crc      <= urcc_pkg::CRC_SEED;
            r_total    <= '0;
            r_expected <= '0;
            r_m_valid  <= 1'b0;
        end else begin
            if (w_pop) begin
                r_phase    <= n_phase;
                r_crc      <= n_crc;
                r_total    <= n_total;
                r_expected <= n_expected;
                r_m_valid  <= 1'b1;
            end else if (i_m_ready) begin
                r_m_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_m_data <= {3'd0, w_reset_req, w_status, n_total, n_crc, n_phase};
        end
    end

endmodule

// File: rtl/update_receiver_crc_check_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// update_receiver_crc_check_core
// firmware image receive controller with word-wise crc-32 verification
// ----------------------------------------------------------------------------
// one result item per input item, sustained one item per clock while the
// result side accepts; an item's result is offered after it has passed the
// front register, the queue and the result register. the rate is set by
// the back stage, which folds a full word into the running crc (poly
// 04c11db7, msb first, seed all ones) through a flat xor network; the
// word-only half of that network sits in the front stage. a two-entry
// queue lets the input keep flowing while the result side stalls, until
// the queue fills.
module update_receiver_crc_check_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // data_word, byte_count, expected_crc, flash_ok, zero pad
    input  logic [71:0] s_axis_tdata,
    // command
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // phase, crc_value, received_bytes, status, reset_request, zero pad
    output logic [71:0] m_axis_tdata
);

`include "update_receiver_crc_check_core_defines.svh"

    logic             w_f_valid;
    logic             w_f_ready;
    urcc_pkg::t_entry w_f_entry;
    logic             w_q_valid;
    logic             w_q_ready;
    urcc_pkg::t_entry w_q_entry;
    logic             w_res_req;
    logic             w_res_done_ok;
    logic             w_res_mismatch;
    logic             w_res_idle;
    logic             w_q_pop;

    urcc_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (s_axis_tvalid),
        .o_ready        (s_axis_tready),
        .i_command      (s_axis_tuser),
        .i_data_word    (s_axis_tdata[31:0]),
        .i_byte_count   (s_axis_tdata[34:32]),
        .i_expected_crc (s_axis_tdata[66:35]),
        .i_flash_ok     (s_axis_tdata[67]),
        .o_valid        (w_f_valid),
        .i_ready        (w_f_ready),
        .o_entry        (w_f_entry)
    );

    urcc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .i_entry (w_f_entry),
        .o_valid (w_q_valid),
        .i_ready (w_q_ready),
        .o_entry (w_q_entry)
    );

    urcc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_q_valid),
        .o_ready   (w_q_ready),
        .i_entry   (w_q_entry),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .o_m_data  (m_axis_tdata)
    );

    assign w_res_req      = m_axis_tvalid && m_axis_tdata[68];
    assign w_res_done_ok  = (m_axis_tdata[1:0] == urcc_pkg::PH_DONE)
                         && (m_axis_tdata[67:66] == urcc_pkg::ST_OK);
    assign w_res_mismatch = m_axis_tvalid && (m_axis_tdata[67:66] == urcc_pkg::ST_MISMATCH);
    assign w_res_idle     = (m_axis_tdata[1:0] == urcc_pkg::PH_IDLE);
    assign w_q_pop        = w_q_valid && w_q_ready && !m_axis_tvalid;

    `URCC_ASSERT_NOW(a_reset_req_done, i_clk, i_rst_n, w_res_req, w_res_done_ok, "stray reset request")
    `URCC_ASSERT_NOW(a_mismatch_idle, i_clk, i_rst_n, w_res_mismatch, w_res_idle, "mismatch not idle")
    `URCC_ASSERT_NEXT(a_queue_drain, i_clk, i_rst_n, w_q_pop, m_axis_tvalid, "queued item lost")

endmodule
